// File: design/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CCOL_W  = $clog2(COLUMNS);
  localparam int CROW_W  = $clog2(ROWS + 1);

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] MOVE_CELLS = ADDR_W'(CELLS - COLUMNS);
  localparam logic [8:0]        COL_LIM    = 9'(COLUMNS);
  localparam logic [8:0]        ROW_LIM    = 9'(ROWS);
  localparam logic [CCOL_W-1:0] COL_LAST   = CCOL_W'(COLUMNS - 1);
  localparam logic [CROW_W-1:0] ROW_LAST   = CROW_W'(ROWS - 1);
  localparam logic [CROW_W-1:0] ROW_END    = CROW_W'(ROWS);

  localparam logic [1:0] ACT_CHAR  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [7:0] CH_NUL       = 8'd0;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] FILL_ATTR    = 8'h0F;

  typedef enum logic [2:0] {
    KD_NOP,
    KD_CHAR,
    KD_NEWLINE,
    KD_BACKSPACE,
    KD_CLEAR,
    KD_WRITE,
    KD_READ
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        ch;
    logic [7:0]        attr;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] r,
                                                  input logic [ADDR_W-1:0] c);
    cell_addr = r * COLS_A + c;
  endfunction

endpackage
`default_nettype wire

// File: design/text_console_writer.sv
`default_nettype none
// channel   valid      stall      payload
// request   req_valid  req_stall  action, char_code, color, column, row
// result    rsp_valid  rsp_stall  read_char, read_color, cursor_col, cursor_row, scrolled
//
// A request enters a two-entry queue; the executor takes one per cycle while it is
// idle and the result register is free. Char, newline, backspace and write_at are
// done in the idle state; read_cell also passes a read state (registered RAM read).
// Clear sweeps the whole cell RAM; a scroll copies COLUMNS*(ROWS-1) cells, reading
// one row ahead, then blanks the last row, one write per cycle.
// Synchronous reset homes the cursor; cell RAM is not cleared.
// req_stall rises when the queue is full; rsp_stall holds the result register.
module text_console_writer import tcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [1:0]        action,
  input  wire logic [7:0]        char_code,
  input  wire logic [7:0]        color,
  input  wire logic signed [8:0] column,
  input  wire logic signed [8:0] row,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic [7:0]             read_char,
  output logic [7:0]             read_color,
  output logic [6:0]             cursor_col,
  output logic [4:0]             cursor_row,
  output logic                   scrolled
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .char_code (char_code),
    .color     (color),
    .column    (column),
    .row       (row),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_char  (read_char),
    .read_color (read_color),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

endmodule
`default_nettype wire

// File: design/tcw_ram.sv
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/tcw_front.sv
`default_nettype none
module tcw_front import tcw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire logic [1:0]       action,
  input  wire logic [7:0]       char_code,
  input  wire logic [7:0]       color,
  input  wire logic signed [8:0] column,
  input  wire logic signed [8:0] row,
  output cmd_t                  cmd,
  output logic                  cmd_valid,
  input  wire logic             cmd_pop
);

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       on_screen;
  cmd_t       cls;

  // negative positions have the sign bit set and fail the check
  assign on_screen = !column[8] && (column < COL_LIM) && !row[8] && (row < ROW_LIM);

  always_comb begin
    cls.ch   = char_code;
    cls.attr = color;
    cls.addr = cell_addr(ADDR_W'(row[7:0]), ADDR_W'(column[7:0]));
    case (action)
      ACT_CHAR: begin
        if (char_code == CH_NEWLINE) begin
          cls.kind = KD_NEWLINE;
        end else if (char_code == CH_BACKSPACE) begin
          cls.kind = KD_BACKSPACE;
        end else if (char_code == CH_NUL) begin
          cls.kind = KD_NOP;
        end else begin
          cls.kind = KD_CHAR;
        end
      end
      ACT_CLEAR: cls.kind = KD_CLEAR;
      ACT_WRITE: cls.kind = on_screen ? KD_WRITE : KD_NOP;
      ACT_READ:  cls.kind = on_screen ? KD_READ : KD_NOP;
      default:   cls.kind = KD_NOP;
    endcase
  end

  assign req_stall = count[1];
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (cmd_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

// File: design/tcw_back.sv
`default_nettype none
module tcw_back import tcw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  cmd,
  input  wire logic  cmd_valid,
  output logic       cmd_pop,
  output logic       rsp_valid,
  input  wire logic  rsp_stall,
  output logic [7:0] read_char,
  output logic [7:0] read_color,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic       scrolled
);

  state_t            state, state_next;
  logic [CCOL_W-1:0] cur_col, cur_col_next;
  logic [CROW_W-1:0] cur_row, cur_row_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              wp, wp_next;
  logic [ADDR_W-1:0] wp_addr, wp_addr_next;
  logic [15:0]       fill, fill_next;
  logic              scr, scr_next;

  logic              res_valid, res_valid_next;
  logic [7:0]        res_char, res_char_next;
  logic [7:0]        res_color, res_color_next;
  logic [CCOL_W-1:0] res_col, res_col_next;
  logic [CROW_W-1:0] res_row, res_row_next;
  logic              res_scr, res_scr_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_col   <= '0;
      cur_row   <= '0;
      wp        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      wp        <= wp_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    wp_addr   <= wp_addr_next;
    fill      <= fill_next;
    scr       <= scr_next;
    res_char  <= res_char_next;
    res_color <= res_color_next;
    res_col   <= res_col_next;
    res_row   <= res_row_next;
    res_scr   <= res_scr_next;
  end

  always_comb begin
    logic [CCOL_W-1:0] nc;
    logic [CROW_W-1:0] nr;
    logic [CCOL_W-1:0] wc;
    logic [CROW_W-1:0] wr;
    logic [15:0]       wd;
    logic              do_wr;

    state_next     = state;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    cnt_next       = cnt;
    wp_next        = wp;
    wp_addr_next   = wp_addr;
    fill_next      = fill;
    scr_next       = scr;
    res_valid_next = res_valid && rsp_stall;
    res_char_next  = res_char;
    res_color_next = res_color;
    res_col_next   = res_col;
    res_row_next   = res_row;
    res_scr_next   = res_scr;
    ram_we         = 1'b0;
    ram_waddr      = cnt;
    ram_wdata      = fill;
    ram_raddr      = cnt + COLS_A;
    cmd_pop        = 1'b0;
    nc             = cur_col;
    nr             = cur_row;
    wc             = cur_col;
    wr             = cur_row;
    wd             = {cmd.attr, CH_SPACE};
    do_wr          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cmd_valid && (!res_valid || !rsp_stall)) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KD_NEWLINE: begin
              nc = '0;
              nr = cur_row + 1'b1;
            end
            KD_BACKSPACE: begin
              if (cur_col != '0) begin
                nc    = cur_col - 1'b1;
                wc    = nc;
                do_wr = 1'b1;
              end else if (cur_row != '0) begin
                nr    = cur_row - 1'b1;
                nc    = COL_LAST;
                wc    = nc;
                wr    = nr;
                do_wr = 1'b1;
              end
            end
            KD_CHAR: begin
              wd    = {cmd.attr, cmd.ch};
              do_wr = 1'b1;
              if (cur_col == COL_LAST) begin
                nc = '0;
                nr = cur_row + 1'b1;
              end else begin
                nc = cur_col + 1'b1;
              end
            end
            KD_CLEAR: begin
              nc         = '0;
              nr         = '0;
              cnt_next   = '0;
              fill_next  = {cmd.attr, CH_SPACE};
              scr_next   = 1'b0;
              state_next = ST_FILL;
            end
            KD_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = cmd.addr;
              ram_wdata = {cmd.attr, cmd.ch};
            end
            KD_READ: begin
              ram_raddr  = cmd.addr;
              state_next = ST_READ;
            end
            default: begin
            end
          endcase

          if (do_wr) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(ADDR_W'(wr), ADDR_W'(wc));
            ram_wdata = wd;
          end

          cur_col_next = nc;
          if (nr == ROW_END) begin
            // ran off the bottom: move rows up, then blank the last one
            cur_row_next = ROW_LAST;
            cnt_next     = '0;
            wp_next      = 1'b0;
            fill_next    = {FILL_ATTR, CH_SPACE};
            scr_next     = 1'b1;
            state_next   = ST_COPY;
          end else begin
            cur_row_next = nr;
          end

          if (state_next == ST_IDLE) begin
            res_valid_next = 1'b1;
            res_char_next  = '0;
            res_color_next = '0;
            res_col_next   = nc;
            res_row_next   = nr;
            res_scr_next   = 1'b0;
          end
        end
      end

      ST_READ: begin
        state_next     = ST_IDLE;
        res_valid_next = 1'b1;
        res_char_next  = ram_rdata[7:0];
        res_color_next = ram_rdata[15:8];
        res_col_next   = cur_col;
        res_row_next   = cur_row;
        res_scr_next   = 1'b0;
      end

      ST_COPY: begin
        // read one row ahead, write the cell back from the registered read data
        if (wp) begin
          ram_we    = 1'b1;
          ram_waddr = wp_addr;
          ram_wdata = ram_rdata;
        end
        if (cnt != MOVE_CELLS) begin
          wp_next      = 1'b1;
          wp_addr_next = cnt;
          cnt_next     = cnt + 1'b1;
        end else begin
          wp_next    = 1'b0;
          state_next = ST_FILL;
        end
      end

      ST_FILL: begin
        ram_we = 1'b1;
        if (cnt == CELL_LAST) begin
          state_next     = ST_IDLE;
          res_valid_next = 1'b1;
          res_char_next  = '0;
          res_color_next = '0;
          res_col_next   = cur_col;
          res_row_next   = cur_row;
          res_scr_next   = scr;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid  = res_valid;
  assign read_char  = res_char;
  assign read_color = res_color;
  assign cursor_col = 7'(res_col);
  assign cursor_row = 5'(res_row);
  assign scrolled   = res_scr;

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col <= COL_LAST) && (cur_row <= ROW_LAST))
    else $error("cursor out of screen");

  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == ST_IDLE) && (!res_valid || !rsp_stall))
    else $error("request taken while result slot busy");

  a_busy_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY || state == ST_FILL || state == ST_READ) |-> !res_valid)
    else $error("result pending during long operation");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_scr) |-> (res_row == ROW_LAST))
    else $error("scroll result with cursor off last row");

  a_copy_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && wp) |-> ram_we && (ram_waddr < MOVE_CELLS))
    else $error("row copy write missing or out of range");
`endif

endmodule
`default_nettype wire
